>>> rtl/xte_pkg.sv
// ---------------------------------------------------------------------------
// xte_pkg
// Shared types and character codes for the XML text escaper.
// ---------------------------------------------------------------------------
package xte_pkg;

  localparam int unsigned MaxRun   = 6;
  localparam int unsigned LenW     = 3;
  localparam int unsigned CharW    = 7;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  // Register byte addresses
  localparam logic [AddrW-1:0] REG_CTRL_ADDR = 3'd0;

  // Input bytes with special treatment
  localparam logic [7:0] B_AMP   = 8'h26;
  localparam logic [7:0] B_LT    = 8'h3C;
  localparam logic [7:0] B_QUOT  = 8'h22;
  localparam logic [7:0] B_DROP1 = 8'h81;
  localparam logic [7:0] B_DROP2 = 8'h82;
  localparam logic [7:0] B_BOLD  = 8'h86;
  localparam logic [7:0] B_UNBOLD = 8'h87;
  localparam logic [7:0] B_BREAK = 8'h8A;

  // Output characters
  localparam logic [CharW-1:0] C_AMP   = 7'h26;  // &
  localparam logic [CharW-1:0] C_HASH  = 7'h23;  // #
  localparam logic [CharW-1:0] C_SEMI  = 7'h3B;  // ;
  localparam logic [CharW-1:0] C_LT    = 7'h3C;  // <
  localparam logic [CharW-1:0] C_GT    = 7'h3E;  // >
  localparam logic [CharW-1:0] C_SLASH = 7'h2F;  // /
  localparam logic [CharW-1:0] C_ZERO  = 7'h30;  // 0
  localparam logic [CharW-1:0] C_A     = 7'h61;
  localparam logic [CharW-1:0] C_B     = 7'h62;
  localparam logic [CharW-1:0] C_L     = 7'h6C;
  localparam logic [CharW-1:0] C_M     = 7'h6D;
  localparam logic [CharW-1:0] C_O     = 7'h6F;
  localparam logic [CharW-1:0] C_P     = 7'h70;
  localparam logic [CharW-1:0] C_Q     = 7'h71;
  localparam logic [CharW-1:0] C_R     = 7'h72;
  localparam logic [CharW-1:0] C_T     = 7'h74;
  localparam logic [CharW-1:0] C_U     = 7'h75;
  localparam logic [CharW-1:0] C_FILL  = 7'h20;

  // One decoded run: characters in order, index 0 first
  typedef struct packed {
    logic [LenW-1:0]                len;
    logic [MaxRun-1:0][CharW-1:0]   chars;
  } run_t;

endpackage

>>> rtl/xte_decode.sv
// ---------------------------------------------------------------------------
// xte_decode
// Map one text byte to its escaped character run and run length.
// ---------------------------------------------------------------------------
module xte_decode import xte_pkg::*; (
  input  logic [7:0] in_byte,
  input  logic       tags_en,
  output run_t       run
);

  logic [7:0] rem;
  logic [1:0] hundreds;
  logic [6:0] low;
  logic [3:0] tens;
  logic [3:0] units;
  logic [14:0] tens_prod;

  // Split a byte of 128..255 into decimal digits
  always_comb begin
    if (in_byte >= 8'd200) begin
      hundreds = 2'd2;
      rem      = in_byte - 8'd200;
    end else begin
      hundreds = 2'd1;
      rem      = in_byte - 8'd100;
    end
    low       = rem[6:0];
    // x*205 >> 11 equals x/10 for x below 100
    tens_prod = 15'(low) * 15'd205;
    tens      = tens_prod[14:11];
    units     = 4'(low - 7'(tens) * 7'd10);
  end

  always_comb begin
    run.len   = '0;
    run.chars = {MaxRun{C_FILL}};
    priority if (in_byte == B_AMP) begin
      run.len   = 3'd5;
      run.chars = {C_FILL, C_SEMI, C_P, C_M, C_A, C_AMP};
    end else if (in_byte == B_LT) begin
      run.len   = 3'd4;
      run.chars = {C_FILL, C_FILL, C_SEMI, C_T, C_L, C_AMP};
    end else if (in_byte == B_QUOT) begin
      run.len   = 3'd6;
      run.chars = {C_SEMI, C_T, C_O, C_U, C_Q, C_AMP};
    end else if (in_byte == B_DROP1 || in_byte == B_DROP2) begin
      run.len   = 3'd0;
    end else if (in_byte == B_BOLD) begin
      run.len   = tags_en ? 3'd3 : 3'd0;
      run.chars = {C_FILL, C_FILL, C_FILL, C_GT, C_B, C_LT};
    end else if (in_byte == B_UNBOLD) begin
      run.len   = tags_en ? 3'd4 : 3'd0;
      run.chars = {C_FILL, C_FILL, C_GT, C_B, C_SLASH, C_LT};
    end else if (in_byte == B_BREAK) begin
      run.len   = tags_en ? 3'd5 : 3'd0;
      run.chars = {C_FILL, C_GT, C_SLASH, C_R, C_B, C_LT};
    end else if (in_byte < 8'd32) begin
      run.len   = 3'd0;
    end else if (in_byte < 8'd128) begin
      run.len      = 3'd1;
      run.chars[0] = in_byte[6:0];
    end else begin
      run.len   = 3'd6;
      run.chars = {C_SEMI, C_ZERO + 7'(units), C_ZERO + 7'(tens),
                   C_ZERO + 7'(hundreds), C_HASH, C_AMP};
    end
  end

endmodule

>>> rtl/xml_text_escaper_unit.sv
// ---------------------------------------------------------------------------
// xml_text_escaper_unit
// Stream escaper that turns text bytes into XML-safe ASCII character runs.
// ---------------------------------------------------------------------------
// Each accepted byte yields a run of zero to six characters, one character
// per output transfer, with last_of_run set on the final one. Plain text
// bytes that map to a single character stream at one byte per clock while
// the output register is free; a byte that expands to more than one
// character holds the input register until its last character is loaded
// into the output register. Dropped bytes free it at once, with no output.
// Register 0 (byte address 0, bit 0) enables markup tags for the bold and
// line-break control bytes; write it only while the block is idle.
// ---------------------------------------------------------------------------
module xml_text_escaper_unit import xte_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // byte input
  input  logic [7:0]       in_byte,
  input  logic             in_valid,
  output logic             in_ready,
  // character output
  output logic [CharW-1:0] out_char,
  output logic             last_of_run,
  output logic             out_valid,
  input  logic             out_ready,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic            tags_en;
  logic [7:0]      byte_q;
  logic            byte_valid;
  logic [LenW-1:0] pos;
  run_t            run;
  logic            out_load;
  logic            at_last;
  logic            release_byte;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_CTRL_ADDR) ? DataW'(tags_en) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tags_en <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_CTRL_ADDR) begin
      tags_en <= pwdata[0];
    end
  end

  // Decode the held byte into its character run
  xte_decode u_decode (
    .in_byte (byte_q),
    .tags_en (tags_en),
    .run     (run)
  );

  // Load the output register from a held, non-dropped byte whenever it is empty or being drained
  assign out_load     = byte_valid && run.len != '0 && (!out_valid || out_ready);
  assign at_last      = pos == run.len - 3'd1;
  // Free the input register on its last character, or at once if dropped
  assign release_byte = byte_valid && (run.len == '0 || (out_load && at_last));
  assign in_ready     = !byte_valid || release_byte;

  // Input register and run position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      pos        <= '0;
    end else begin
      if (in_valid && in_ready) begin
        byte_valid <= 1'b1;
      end else if (release_byte) begin
        byte_valid <= 1'b0;
      end
      if (release_byte) begin
        pos <= '0;
      end else if (out_load) begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= in_byte;
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char    <= run.chars[pos];
      last_of_run <= at_last;
    end
  end

endmodule

>>> tb/xml_text_escaper_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// xml_text_escaper_unit_tb
// Self-checking bench for the XML text escaper: directed bytes for entities,
// dropped codes, markup tags and decimal references, then random text in
// several register settings with random idling and a long output stall.
// ---------------------------------------------------------------------------
module xml_text_escaper_unit_tb;
  import xte_pkg::*;

  // One expected output character, tagged with the byte that caused it
  typedef struct {
    logic [CharW-1:0] ch;
    logic             is_last;
    logic [7:0]       src;
  } char_exp_t;

  logic             clk;
  logic             rst;
  logic [7:0]       in_byte;
  logic             in_valid;
  logic             in_ready;
  logic [CharW-1:0] out_char;
  logic             last_of_run;
  logic             out_valid;
  logic             out_ready;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Expected characters in output order, oldest first
  char_exp_t        pending_chars[$];
  char_exp_t        got;
  logic             tags_on;        // mirror of tags_en in the control register
  int unsigned      idle_pct;       // chance of an idle cycle, per side
  int unsigned      stall_cycles;   // receiver hold-off still to run
  int unsigned      errors;
  int unsigned      mismatches;
  int unsigned      bytes_sent;
  int unsigned      chars_seen;
  int unsigned      reg_writes;

  xml_text_escaper_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on either channel
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Pack a literal string into a character run
  function automatic run_t text_run(input string s);
    run_t r;
    r = '0;
    r.len = LenW'(s.len());
    for (int i = 0; i < s.len(); i++) r.chars[i] = CharW'(s[i]);
    return r;
  endfunction

  // Escaped form of one byte under the given tag setting
  function automatic run_t escape_run(input logic [7:0] b, input logic tags);
    run_t r;
    r = '0;
    case (b)
      B_AMP:            r = text_run("&amp;");
      B_LT:             r = text_run("&lt;");
      B_QUOT:           r = text_run("&quot;");
      B_DROP1, B_DROP2: r = '0;
      B_BOLD:           if (tags) r = text_run("<b>");
      B_UNBOLD:         if (tags) r = text_run("</b>");
      B_BREAK:          if (tags) r = text_run("<br/>");
      default: begin
        if (b >= 8'd128) begin
          // decimal character reference, always three digits
          r.len      = LenW'(6);
          r.chars[0] = C_AMP;
          r.chars[1] = C_HASH;
          r.chars[2] = C_ZERO + CharW'(b / 8'd100);
          r.chars[3] = C_ZERO + CharW'((b / 8'd10) % 8'd10);
          r.chars[4] = C_ZERO + CharW'(b % 8'd10);
          r.chars[5] = C_SEMI;
        end else if (b >= 8'd32) begin
          r.len      = LenW'(1);
          r.chars[0] = b[CharW-1:0];
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------

  // Offer one byte, hold it until the transfer, then queue its run
  task automatic send_byte(input logic [7:0] b);
    run_t r;
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (!in_ready);
    r = escape_run(b, tags_on);
    for (int k = 0; k < r.len; k++)
      pending_chars.push_back('{ch: r.chars[k], is_last: (k == r.len - 1), src: b});
    bytes_sent++;
  endtask

  // Drop valid, drain every expected character, then allow for a dropped
  // byte still in flight before the next register access
  task automatic wait_idle();
    int unsigned waited;
    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (pending_chars.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_chars.size() != 0) begin
      $display("ERROR: %0d expected characters never arrived", pending_chars.size());
      errors += pending_chars.size();
      pending_chars.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  // Two-phase register write; the mirror follows only the one real register
  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_CTRL_ADDR) tags_on = data[0];
    reg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Two-phase register read, compared against the mirror
  task automatic reg_read_check();
    logic [DataW-1:0] value;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = REG_CTRL_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    if (value[0] !== tags_on || value[DataW-1:1] !== '0) begin
      $display("ERROR: control register reads %h, expected %0d", value, tags_on);
      errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random idling, plus a counted hold-off when requested
  // ---------------------------------------------------------------------
  initial begin
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (stall_cycles != 0) begin
        out_ready = 1'b0;
        stall_cycles--;
      end else begin
        out_ready = (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: compare each output transfer with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected character %h last=%b", out_char, last_of_run);
      end else begin
        got = pending_chars.pop_front();
        if (out_char !== got.ch || last_of_run !== got.is_last) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: byte %h: char %h last=%b, expected char %h last=%b",
                     got.src, out_char, last_of_run, got.ch, got.is_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------

  // Printable edges and the three entities, tags off after reset
  task automatic test_printable_entities();
    send_byte(8'd32);
    send_byte(8'd127);
    send_byte(B_AMP);
    send_byte(B_LT);
    send_byte(B_QUOT);
    send_byte(8'h41);
    send_byte(8'h3E);
    send_byte(8'h7E);
    wait_idle();
  endtask

  // Control bytes, the two always-dropped codes, tag codes with tags off,
  // and decimal references at the top half's edges
  task automatic test_drops_and_refs();
    send_byte(8'h00);
    send_byte(8'h1F);
    send_byte(B_DROP1);
    send_byte(B_DROP2);
    send_byte(B_BOLD);
    send_byte(B_UNBOLD);
    send_byte(B_BREAK);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hC8);
    wait_idle();
  endtask

  // Tag codes with tags on, an ignored write to an unused address, and a
  // write whose upper bits must not matter
  task automatic test_markup_tags();
    reg_write(REG_CTRL_ADDR, 32'd1);
    reg_read_check();
    send_byte(B_BOLD);
    send_byte(B_UNBOLD);
    send_byte(B_BREAK);
    send_byte(8'h0A);
    send_byte(B_DROP1);
    wait_idle();
    reg_write(AddrW'(4), 32'd0);
    reg_read_check();
    send_byte(B_BOLD);
    wait_idle();
    reg_write(REG_CTRL_ADDR, 32'hFFFF_FFFE);
    reg_read_check();
    send_byte(B_BOLD);
    send_byte(B_AMP);
    wait_idle();
  endtask

  // Random text in four phases; each phase sets the register afresh,
  // alternating between both values with random upper bits
  task automatic test_random_text();
    logic [7:0]       b;
    logic [DataW-1:0] data;
    logic [7:0]       specials[8];
    specials = '{B_AMP, B_LT, B_QUOT, B_DROP1, B_DROP2, B_BOLD, B_UNBOLD, B_BREAK};
    for (int phase = 0; phase < 4; phase++) begin
      data = ($urandom() & ~32'h1) | DataW'(phase % 2);
      reg_write(REG_CTRL_ADDR, data);
      // one phase runs with no idling on either side
      idle_pct = (phase == 2) ? 0 : 12;
      for (int n = 0; n < 40; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: b = 8'($urandom_range(127, 32));
          5, 6:          b = specials[$urandom_range(7)];
          7, 8:          b = 8'($urandom_range(255, 128));
          default:       b = 8'($urandom_range(255));
        endcase
        send_byte(b);
      end
      wait_idle();
    end
    idle_pct = 12;
  endtask

  // Hold the output for a long stretch while long runs keep arriving, so
  // the block fills and stalls its input, then release and drain
  task automatic test_output_stall();
    stall_cycles = 150;
    for (int n = 0; n < 24; n++) send_byte(8'($urandom_range(255, 128)));
    wait_idle();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    in_byte      = '0;
    in_valid     = 1'b0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    tags_on      = 1'b0;
    idle_pct     = 12;
    stall_cycles = 0;
    errors       = 0;
    mismatches   = 0;
    bytes_sent   = 0;
    chars_seen   = 0;
    reg_writes   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    reg_read_check();
    test_printable_entities();
    test_drops_and_refs();
    test_markup_tags();
    test_random_text();
    test_output_stall();

    $display("Run covered %0d input bytes, %0d output characters and %0d register writes,",
             bytes_sent, chars_seen, reg_writes);
    $display("with entities, dropped codes, tags on and off, and a long output stall.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/xte_pkg.sv
rtl/xte_decode.sv
rtl/xml_text_escaper_unit.sv
tb/xml_text_escaper_unit_tb.sv
